### rtl/core/ssdo_pkg.sv
// ---------------------------------------------------------------------------
// ssdo_pkg: shared definitions for the state-space disturbance observer
// Field widths, register codes, default sizes, the pipeline tag and the
// 32-bit saturation helper used by the sequencer and the MAC datapath.
// ---------------------------------------------------------------------------
package ssdo_pkg;

  // default sizes of the observer
  localparam int STATE_COUNT_DEF = 6;
  localparam int DIST_COUNT_DEF  = 2;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int ACC_WIDTH_DEF   = 64;

  // fixed field widths
  localparam int DATA_W       = 32;
  localparam int STEP_W       = 24;
  localparam int LIMIT_W      = 31;
  localparam int FUNC_W       = 2;
  localparam int WIDX_W       = 7;
  localparam int MEAS_FIELDS  = 6;
  localparam int DRIVE_FIELDS = 2;
  localparam int MEAS_IDX_W   = $clog2(MEAS_FIELDS);
  localparam int OUT_FIELDS   = MEAS_FIELDS + DRIVE_FIELDS;

  // stream and configuration port widths
  localparam int WIDX_LSB     = DATA_W * (MEAS_FIELDS + DRIVE_FIELDS);
  localparam int WVAL_LSB     = WIDX_LSB + WIDX_W;
  localparam int IN_TDATA_W   = ((WVAL_LSB + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = DATA_W * OUT_FIELDS;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 31;

  // register reset values
  localparam logic [STEP_W-1:0]  STEP_RESET   = 24'd16777;
  localparam logic [LIMIT_W-1:0] LIMIT0_RESET = 31'd131072;
  localparam logic [LIMIT_W-1:0] LIMIT1_RESET = 31'd655360;

  // wide intermediate width for saturating sums
  localparam int WIDE_W = 66;
  localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

  // input item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_COEF   = 2'd1,
    FUNC_PRESET = 2'd2
  } func_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP   = 2'd0,
    CFG_LIMIT0 = 2'd1,
    CFG_LIMIT1 = 2'd2
  } cfg_reg_t;

  // tag that travels with each multiply-accumulate term
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_tag_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/ssdo_mac.sv
// ---------------------------------------------------------------------------
// ssdo_mac: multiply-accumulate and integration pipeline
// Takes one coefficient/operand pair per cycle, accumulates a row with
// saturation, then integrates the row rate into a new estimate.
// ---------------------------------------------------------------------------
module ssdo_mac #(
  parameter int STATE_COUNT       = ssdo_pkg::STATE_COUNT_DEF,
  parameter int DISTURBANCE_COUNT = ssdo_pkg::DIST_COUNT_DEF,
  parameter int FRAC_BITS         = ssdo_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH         = ssdo_pkg::ACC_WIDTH_DEF,
  localparam int ROWS             = STATE_COUNT + DISTURBANCE_COUNT,
  localparam int ROW_W            = $clog2(ROWS)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  ssdo_pkg::mac_tag_t                    tag,
  input  logic signed [ssdo_pkg::DATA_W-1:0]    coef,
  input  logic signed [ssdo_pkg::DATA_W-1:0]    operand,
  input  logic signed [ssdo_pkg::DATA_W-1:0]    old_est [ROWS],
  input  logic        [ssdo_pkg::STEP_W-1:0]    step_size,
  input  logic        [ssdo_pkg::LIMIT_W-1:0]   limit0,
  input  logic        [ssdo_pkg::LIMIT_W-1:0]   limit1,
  output logic                                  wb_vld,
  output logic        [ROW_W-1:0]               wb_row,
  output logic signed [ssdo_pkg::DATA_W-1:0]    wb_val,
  output logic                                  busy
);
  import ssdo_pkg::*;

  localparam int PROD_W  = 2 * DATA_W;
  localparam int SPROD_W = STEP_W + 1 + DATA_W;
  localparam logic signed [WIDE_W-1:0] ONE_W  = WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] ACC_HI = (ONE_W <<< (ACC_WIDTH - 1)) - ONE_W;
  localparam logic signed [WIDE_W-1:0] ACC_LO = -ACC_HI - ONE_W;

  mac_tag_t                   s2_tag_r;
  logic signed [PROD_W-1:0]   s2_prod_r;
  logic signed [PROD_W-1:0]   term;
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic signed [ACC_WIDTH-1:0] acc_base;
  logic signed [ACC_WIDTH-1:0] acc_nxt;
  logic signed [WIDE_W-1:0]   acc_sum;
  logic                       s3_vld_r;
  logic                       s4_vld_r;
  logic                       s5_vld_r;
  logic signed [DATA_W-1:0]   rate_r;
  logic signed [SPROD_W-1:0]  step_prod_r;
  logic signed [SPROD_W-1:0]  delta;
  logic signed [DATA_W-1:0]   integ;
  logic        [LIMIT_W-1:0]  lim;
  logic signed [DATA_W:0]     lim_s;
  logic        [ROW_W-1:0]    row_r;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r <= '0;
    end else begin
      s2_tag_r <= tag;
    end
    s2_prod_r <= coef * operand;
  end

  // floor shift of the product, saturating add into the row accumulator
  always_comb begin
    term     = s2_prod_r >>> FRAC_BITS;
    acc_base = s2_tag_r.first ? '0 : acc_r;
    acc_sum  = WIDE_W'(acc_base) + WIDE_W'(term);
    if (acc_sum > ACC_HI) begin
      acc_nxt = ACC_HI[ACC_WIDTH-1:0];
    end else if (acc_sum < ACC_LO) begin
      acc_nxt = ACC_LO[ACC_WIDTH-1:0];
    end else begin
      acc_nxt = acc_sum[ACC_WIDTH-1:0];
    end
  end

  // accumulate, then saturate the row rate and scale it by the step size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      row_r    <= '0;
    end else begin
      s3_vld_r <= s2_tag_r.vld & s2_tag_r.last;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      if (start) begin
        row_r <= '0;
      end else if (s5_vld_r) begin
        row_r <= row_r + ROW_W'(1);
      end
    end
    if (s2_tag_r.vld) begin
      acc_r <= acc_nxt;
    end
    rate_r      <= sat32(WIDE_W'(acc_r));
    step_prod_r <= signed'({1'b0, step_size}) * rate_r;
  end

  // integrate into the old estimate, clamp disturbance rows
  always_comb begin
    delta = step_prod_r >>> STEP_W;
    integ = sat32(WIDE_W'(old_est[row_r]) + WIDE_W'(delta));
    lim   = (row_r == ROW_W'(STATE_COUNT)) ? limit0 : limit1;
    lim_s = signed'({2'b00, lim});
    wb_val = integ;
    if (row_r >= ROW_W'(STATE_COUNT)) begin
      if (integ > lim_s) begin
        wb_val = lim_s[DATA_W-1:0];
      end else if (integ < -lim_s) begin
        wb_val = DATA_W'(-lim_s);
      end
    end
  end

  assign wb_vld = s5_vld_r;
  assign wb_row = row_r;
  assign busy   = s2_tag_r.vld | s3_vld_r | s4_vld_r | s5_vld_r;

endmodule

### rtl/core/state_space_disturbance_observer.sv
// ---------------------------------------------------------------------------
// state_space_disturbance_observer: extended state observer, Q16.16
// Coefficient memory, estimate registers and a sequencer that drives one
// shared multiply-accumulate pipeline through A x + B (u + d) + L e.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per item. tuser selects update, coefficient write or
//           estimate preset. Loads give no result.
//   out_* : one transfer per executed update with all new estimates.
//   cfg_* : step size and the two disturbance limits, written while idle.
// An update issues one coefficient read and one MAC term per cycle:
//   STATE_COUNT * (2 * STATE_COUNT + DISTURBANCE_COUNT)
//   + DISTURBANCE_COUNT * STATE_COUNT terms (96 at default sizes), then
//   pipeline drain and integration and a commit step; the single coefficient
//   read port and the shared multiplier force that serial issue.
// An update arriving before every coefficient was written at least once,
// and the unused function code, are dropped without a result.
// Reset restores the registers, zeroes all estimates and forgets which
// coefficients were loaded; the coefficient contents are not cleared.
// A stalled receiver holds the result; the next load is still accepted, and
// the next update runs but waits at commit until the result is taken.
// ---------------------------------------------------------------------------
module state_space_disturbance_observer #(
  parameter int STATE_COUNT       = ssdo_pkg::STATE_COUNT_DEF,
  parameter int DISTURBANCE_COUNT = ssdo_pkg::DIST_COUNT_DEF,
  parameter int FRAC_BITS         = ssdo_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH         = ssdo_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // measured_0..5, drive_0..1, write_index, write_value, one pad bit
  input  logic [ssdo_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func
  input  logic [ssdo_pkg::FUNC_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // estimate_0..5, disturbance_0..1
  output logic [ssdo_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [ssdo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssdo_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssdo_pkg::*;

  localparam int ROWS       = STATE_COUNT + DISTURBANCE_COUNT;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(STATE_COUNT);
  localparam int B_BASE     = STATE_COUNT * STATE_COUNT;
  localparam int L_BASE     = B_BASE + STATE_COUNT * DISTURBANCE_COUNT;
  localparam int COEF_COUNT = L_BASE + ROWS * STATE_COUNT;
  localparam int ADDR_W     = $clog2(COEF_COUNT);
  localparam int CNT_W      = $clog2(COEF_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_L
  } phase_t;

  // configuration registers
  logic [STEP_W-1:0]  step_size_r;
  logic [LIMIT_W-1:0] limit0_r;
  logic [LIMIT_W-1:0] limit1_r;

  // input field views
  logic signed [DATA_W-1:0] meas [MEAS_FIELDS];
  logic signed [DATA_W-1:0] drive [DRIVE_FIELDS];
  logic        [WIDX_W-1:0] widx;
  logic signed [DATA_W-1:0] wval;
  logic                     in_acc;

  // coefficient memory and load tracking
  logic signed [DATA_W-1:0] coef_mem [COEF_COUNT];
  logic signed [DATA_W-1:0] coef_q_r;
  logic                     coef_we;
  logic [COEF_COUNT-1:0]    written_r;
  logic [CNT_W-1:0]         wcount_r;
  logic                     loaded;

  // sequencer
  state_t                   st_r;
  phase_t                   phase_r;
  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic [ADDR_W-1:0]        a_addr_r;
  logic [ADDR_W-1:0]        b_addr_r;
  logic [ADDR_W-1:0]        l_addr_r;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [DATA_W-1:0] y_r [MEAS_FIELDS];
  logic signed [DATA_W-1:0] u_r [DRIVE_FIELDS];
  logic signed [DATA_W-1:0] est_r [ROWS];
  logic signed [DATA_W-1:0] new_r [ROWS];
  logic                     col_last_a;
  logic                     col_last_b;
  logic                     last_row;
  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic [OUT_TDATA_W-1:0]   out_pack;

  // issue stage
  mac_tag_t                 iss_tag;
  mac_tag_t                 s1_tag_r;
  logic signed [DATA_W-1:0] iss_op;
  logic signed [DATA_W-1:0] s1_op_r;
  logic                     dp_start;
  logic                     wb_vld;
  logic [ROW_W-1:0]         wb_row;
  logic signed [DATA_W-1:0] wb_val;
  logic                     dp_busy;

  // unpack the input transfer
  for (genvar j = 0; j < MEAS_FIELDS; j++) begin : g_meas
    assign meas[j] = in_tdata[DATA_W*j +: DATA_W];
  end
  for (genvar k = 0; k < DRIVE_FIELDS; k++) begin : g_drive
    assign drive[k] = in_tdata[DATA_W*(MEAS_FIELDS+k) +: DATA_W];
  end
  assign widx   = in_tdata[WIDX_LSB +: WIDX_W];
  assign wval   = in_tdata[WVAL_LSB +: DATA_W];
  assign in_acc = in_tvalid & in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= STEP_RESET;
      limit0_r    <= LIMIT0_RESET;
      limit1_r    <= LIMIT1_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP:   step_size_r <= cfg_data[STEP_W-1:0];
        CFG_LIMIT0: limit0_r    <= cfg_data[LIMIT_W-1:0];
        CFG_LIMIT1: limit1_r    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficient memory: written only by loads in idle, read while running
  assign coef_we = in_acc && (in_tuser == FUNC_COEF) && (widx < WIDX_W'(COEF_COUNT));

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[widx[ADDR_W-1:0]] <= wval;
    end
    coef_q_r <= coef_mem[rd_addr];
  end

  // track which coefficients were loaded since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      wcount_r  <= '0;
    end else if (coef_we && !written_r[widx[ADDR_W-1:0]]) begin
      written_r[widx[ADDR_W-1:0]] <= 1'b1;
      wcount_r                    <= wcount_r + CNT_W'(1);
    end
  end

  assign loaded = (wcount_r == CNT_W'(COEF_COUNT));

  // select coefficient address and operand for the current term
  always_comb begin
    rd_addr = a_addr_r;
    iss_op  = est_r[ROW_W'(col_r)];
    case (phase_r)
      PH_B: begin
        rd_addr = b_addr_r;
        iss_op  = sat32(WIDE_W'(u_r[col_r[0]]) +
                        WIDE_W'(est_r[ROW_W'(STATE_COUNT) + ROW_W'(col_r)]));
      end
      PH_L: begin
        rd_addr = l_addr_r;
        iss_op  = sat32(WIDE_W'(y_r[MEAS_IDX_W'(col_r)]) -
                        WIDE_W'(est_r[ROW_W'(col_r)]));
      end
      default: ;
    endcase
  end

  assign col_last_a = (col_r == COL_W'(STATE_COUNT - 1));
  assign col_last_b = (col_r == COL_W'(DISTURBANCE_COUNT - 1));
  assign last_row   = (row_r == ROW_W'(ROWS - 1));

  always_comb begin
    iss_tag.vld   = (st_r == ST_RUN);
    iss_tag.first = (col_r == '0) &&
                    ((phase_r == PH_A) ||
                     ((phase_r == PH_L) && (row_r >= ROW_W'(STATE_COUNT))));
    iss_tag.last  = (phase_r == PH_L) && col_last_a;
  end

  // register the term alongside the coefficient read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
    end else begin
      s1_tag_r <= iss_tag;
    end
    s1_op_r <= iss_op;
  end

  assign dp_start = in_acc && (in_tuser == FUNC_UPDATE) && loaded;

  ssdo_mac #(
    .STATE_COUNT       (STATE_COUNT),
    .DISTURBANCE_COUNT (DISTURBANCE_COUNT),
    .FRAC_BITS         (FRAC_BITS),
    .ACC_WIDTH         (ACC_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dp_start),
    .tag       (s1_tag_r),
    .coef      (coef_q_r),
    .operand   (s1_op_r),
    .old_est   (est_r),
    .step_size (step_size_r),
    .limit0    (limit0_r),
    .limit1    (limit1_r),
    .wb_vld    (wb_vld),
    .wb_row    (wb_row),
    .wb_val    (wb_val),
    .busy      (dp_busy)
  );

  // collect new estimates until the whole update is done
  always_ff @(posedge clk) begin
    if (wb_vld) begin
      new_r[wb_row] <= wb_val;
    end
  end

  // pack the result; fields beyond the configured counts stay zero
  for (genvar j = 0; j < MEAS_FIELDS; j++) begin : g_out_est
    if (j < STATE_COUNT) begin : g_used
      assign out_pack[DATA_W*j +: DATA_W] = new_r[j];
    end else begin : g_zero
      assign out_pack[DATA_W*j +: DATA_W] = '0;
    end
  end
  for (genvar k = 0; k < DRIVE_FIELDS; k++) begin : g_out_dist
    if (k < DISTURBANCE_COUNT) begin : g_used
      assign out_pack[DATA_W*(MEAS_FIELDS+k) +: DATA_W] = new_r[STATE_COUNT+k];
    end else begin : g_zero
      assign out_pack[DATA_W*(MEAS_FIELDS+k) +: DATA_W] = '0;
    end
  end

  // sequencer: loads, term issue, drain, commit and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      phase_r      <= PH_A;
      col_r        <= '0;
      row_r        <= '0;
      a_addr_r     <= '0;
      b_addr_r     <= '0;
      l_addr_r     <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        est_r[i] <= '0;
      end
    end else begin
      // drop the result once taken, unless commit reloads it this cycle
      if (out_tvalid_r && out_tready && (st_r != ST_COMMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_tuser)
              FUNC_PRESET: begin
                if (widx < WIDX_W'(ROWS)) begin
                  est_r[widx[ROW_W-1:0]] <= wval;
                end
              end
              FUNC_UPDATE: begin
                if (loaded) begin
                  st_r     <= ST_RUN;
                  phase_r  <= PH_A;
                  col_r    <= '0;
                  row_r    <= '0;
                  a_addr_r <= '0;
                  b_addr_r <= ADDR_W'(B_BASE);
                  l_addr_r <= ADDR_W'(L_BASE);
                  for (int j = 0; j < MEAS_FIELDS; j++) begin
                    y_r[j] <= meas[j];
                  end
                  for (int k = 0; k < DRIVE_FIELDS; k++) begin
                    u_r[k] <= drive[k];
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          case (phase_r)
            PH_A: begin
              a_addr_r <= a_addr_r + ADDR_W'(1);
              if (col_last_a) begin
                phase_r <= PH_B;
                col_r   <= '0;
              end else begin
                col_r <= col_r + COL_W'(1);
              end
            end
            PH_B: begin
              b_addr_r <= b_addr_r + ADDR_W'(1);
              if (col_last_b) begin
                phase_r <= PH_L;
                col_r   <= '0;
              end else begin
                col_r <= col_r + COL_W'(1);
              end
            end
            default: begin
              l_addr_r <= l_addr_r + ADDR_W'(1);
              if (col_last_a) begin
                col_r   <= '0;
                row_r   <= row_r + ROW_W'(1);
                phase_r <= (row_r < ROW_W'(STATE_COUNT - 1)) ? PH_A : PH_L;
                if (last_row) begin
                  st_r <= ST_DRAIN;
                end
              end else begin
                col_r <= col_r + COL_W'(1);
              end
            end
          endcase
        end
        ST_DRAIN: begin
          if (!dp_busy && !s1_tag_r.vld) begin
            st_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (!out_tvalid_r || out_tready) begin
            est_r        <= new_r;
            out_data_r   <= out_pack;
            out_tvalid_r <= 1'b1;
            st_r         <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // an update only runs once every coefficient has been loaded
  a_run_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> loaded)
    else $error("observer update running with coefficients not loaded");

  // load count agrees with the per-entry flags
  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    wcount_r == CNT_W'($countones(written_r)))
    else $error("coefficient load count out of step with flags");

  // write-back happens only while an update is in flight
  a_wb_window: assert property (@(posedge clk) disable iff (!rst_n)
    wb_vld |-> (st_r == ST_RUN || st_r == ST_DRAIN))
    else $error("estimate write-back outside an update");

  // a result appears only out of the commit step
  a_out_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(st_r) == ST_COMMIT))
    else $error("result raised without a commit");

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for state_space_disturbance_observer
// Drives items on the input stream, mirrors the observer arithmetic in Q16.16
// to predict each update, and compares every result transfer field by field.
// A table of probe items covers load corner cases, dropped items and
// saturation. Random phases under several step and limit settings follow,
// with random stalls on both streams and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssdo_pkg::*;

  // observer sizes and coefficient layout
  localparam int NS          = STATE_COUNT_DEF;
  localparam int ND          = DIST_COUNT_DEF;
  localparam int NR          = NS + ND;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int B_BASE      = NS * NS;
  localparam int L_BASE      = B_BASE + NS * ND;
  localparam int COEF_TOTAL  = L_BASE + NR * NS;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam logic [31:0] MAXQ  = 32'h7FFF_FFFF;
  localparam logic [31:0] MINQ  = 32'h8000_0000;
  localparam logic [31:0] ONESQ = 32'hFFFF_FFFF;

  localparam int DRAIN_CYCLES   = 200;
  localparam int HOLD_CYCLES    = 1000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 80;

  // input word, lowest field first: measured, drive, write_index, write_value
  typedef struct packed {
    logic [IN_TDATA_W-WVAL_LSB-DATA_W-1:0] pad;
    logic [DATA_W-1:0]                     wval;
    logic [WIDX_W-1:0]                     widx;
    logic [DRIVE_FIELDS-1:0][DATA_W-1:0]   drv;
    logic [MEAS_FIELDS-1:0][DATA_W-1:0]    meas;
  } in_word_t;

  // result word: estimate_0..5, disturbance_0..1
  typedef struct packed {
    logic [DRIVE_FIELDS-1:0][DATA_W-1:0] disturb;
    logic [MEAS_FIELDS-1:0][DATA_W-1:0]  est;
  } out_word_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WIDX_W-1:0] widx;
    logic [31:0]       wval;
    logic [31:0]       meas;      // copied to every measured field
    logic [31:0]       drv;       // copied to every drive field
    logic              fill;      // load every coefficient with wval
    logic              typed;     // expected result given below
    logic [31:0]       exp_est;   // every estimate
    logic [31:0]       exp_d0;
    logic [31:0]       exp_d1;
  } probe_row_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [LIMIT_W-1:0] l0;
    logic [LIMIT_W-1:0] l1;
    logic               calm;     // no idling on either stream
    logic               squeeze;  // long receiver hold-off
  } phase_t;

  // DUT ports
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // sideband that travels with the offered item
  logic      typed_tag = 1'b0;
  out_word_t typed_want = '0;

  // observer mirror
  logic signed [31:0] coef_mirror [COEF_TOTAL];
  logic               coef_seen [COEF_TOTAL];
  int                 coef_loaded = 0;
  logic signed [31:0] est_mirror [NS];
  logic signed [31:0] dist_mirror [ND];
  logic [STEP_W-1:0]  step_sz = STEP_RESET;
  logic [LIMIT_W-1:0] lim_0 = LIMIT0_RESET;
  logic [LIMIT_W-1:0] lim_1 = LIMIT1_RESET;

  out_word_t pending_estimates [$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 26;
  int        rx_idle_pct = 26;
  logic      squeeze_req = 1'b0;
  logic      squeeze_done = 1'b0;
  int        hold_left = 0;

  probe_row_t probe_table [25] = '{
    // update before the coefficients are loaded: dropped
    '{FUNC_UPDATE, 7'd0,   32'h0, MAXQ, MINQ, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    // unused function code
    '{FUNC_SPARE,  7'd0,   MAXQ,  MAXQ, MAXQ, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    // coefficient index past the store: ignored
    '{FUNC_COEF,   7'd96,  MAXQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_COEF,   7'd127, MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    // preset index past the disturbances: ignored
    '{FUNC_PRESET, 7'd8,   MAXQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_PRESET, 7'd127, ONESQ, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    // preset every estimate to the negative extreme
    '{FUNC_PRESET, 7'd0,   MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_PRESET, 7'd1,   MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_PRESET, 7'd2,   MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_PRESET, 7'd3,   MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_PRESET, 7'd4,   MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_PRESET, 7'd5,   MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    // disturbance presets are stored unclamped
    '{FUNC_PRESET, 7'd6,   MAXQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_PRESET, 7'd7,   MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    // all coefficients zero
    '{FUNC_COEF,   7'd0,   32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0},
    // zero rates: estimates hold, disturbances clamp to the default limits
    '{FUNC_UPDATE, 7'd0, 32'h0, MAXQ, MINQ, 1'b0, 1'b1, MINQ, 32'h0002_0000, 32'hFFF6_0000},
    '{FUNC_UPDATE, 7'd0, 32'h0, 32'h0, MAXQ, 1'b0, 1'b1, MINQ, 32'h0002_0000, 32'hFFF6_0000},
    // extreme coefficients in A, B and the disturbance rows of L
    '{FUNC_COEF,   7'd0,   MAXQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_COEF,   7'd36,  MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_COEF,   7'd84,  MAXQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_COEF,   7'd95,  MINQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_UPDATE, 7'd0,   32'h0, MAXQ, MINQ, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_PRESET, 7'd3,   MAXQ,  32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_UPDATE, 7'd0,   32'h0, MINQ, MAXQ, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{FUNC_UPDATE, 7'd0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0}
  };

  state_space_disturbance_observer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // add one Q16.16 product into a saturating 64-bit accumulator
  function automatic longint mac_term(input longint acc, input logic signed [31:0] c,
                                      input logic signed [31:0] x);
    longint t;
    longint s;
    t = (longint'(c) * longint'(x)) >>> FRAC;
    s = acc + t;
    if (acc[63] == t[63] && s[63] != acc[63])
      s = acc[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  // advance one estimate by step_size * rate
  function automatic logic signed [31:0] advance(input logic signed [31:0] old,
                                                 input logic signed [31:0] rate);
    longint delta;
    delta = (longint'(step_sz) * longint'(rate)) >>> STEP_W;
    return clip32(longint'(old) + delta);
  endfunction

  // apply one item to the mirror; returns 1 when an update result is due
  function automatic bit observe_step(input logic [FUNC_W-1:0] f, input in_word_t w,
                                      output out_word_t res);
    logic signed [31:0] e [NS];
    logic signed [31:0] v [ND];
    logic signed [31:0] rate [NR];
    longint acc;
    longint dn;
    longint lim;
    res = '0;
    if (f == FUNC_COEF) begin
      if (w.widx < COEF_TOTAL) begin
        coef_mirror[w.widx] = w.wval;
        if (!coef_seen[w.widx]) begin
          coef_seen[w.widx] = 1'b1;
          coef_loaded++;
        end
      end
      return 1'b0;
    end
    if (f == FUNC_PRESET) begin
      if (w.widx < NS) begin
        est_mirror[w.widx] = w.wval;
      end else if (w.widx < NR) begin
        dist_mirror[w.widx - NS] = w.wval;
      end
      return 1'b0;
    end
    if (f != FUNC_UPDATE || coef_loaded < COEF_TOTAL) return 1'b0;

    // innovation and disturbed drive, from the old estimates
    for (int j = 0; j < NS; j++)
      e[j] = clip32(longint'($signed(w.meas[j])) - longint'(est_mirror[j]));
    for (int k = 0; k < ND; k++)
      v[k] = clip32(longint'($signed(w.drv[k])) + longint'(dist_mirror[k]));

    // rates: A x + B v + L e for plant rows, L e for disturbance rows
    for (int i = 0; i < NR; i++) begin
      acc = 0;
      if (i < NS) begin
        for (int j = 0; j < NS; j++)
          acc = mac_term(acc, coef_mirror[i * NS + j], est_mirror[j]);
        for (int k = 0; k < ND; k++)
          acc = mac_term(acc, coef_mirror[B_BASE + i * ND + k], v[k]);
      end
      for (int j = 0; j < NS; j++)
        acc = mac_term(acc, coef_mirror[L_BASE + i * NS + j], e[j]);
      rate[i] = clip32(acc);
    end

    // integrate, then clamp the disturbances
    for (int i = 0; i < NS; i++) begin
      est_mirror[i] = advance(est_mirror[i], rate[i]);
      res.est[i] = est_mirror[i];
    end
    for (int k = 0; k < ND; k++) begin
      lim = (k == 0) ? longint'(lim_0) : longint'(lim_1);
      dn = longint'(advance(dist_mirror[k], rate[NS + k]));
      if (dn > lim) dn = lim;
      if (dn < -lim) dn = -lim;
      dist_mirror[k] = dn[31:0];
      res.disturb[k] = dist_mirror[k];
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    if (fail_count < 100) $display("[%0t] MISMATCH %s", $realtime, what);
    fail_count++;
  endtask

  // Q16.16 value: mostly small, sometimes an extreme or fully random
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(9))
      0: return MAXQ;
      1: return MINQ;
      2: return $urandom();
      3: return 32'h0;
      default: return 32'($urandom_range(262143)) - 32'd131072;
    endcase
  endfunction

  function automatic in_word_t noisy_word();
    logic [319:0] noise;
    in_word_t w;
    for (int b = 0; b < 10; b++) noise[32 * b +: 32] = $urandom();
    w = in_word_t'(noise[IN_TDATA_W-1:0]);
    w.pad = '0;
    return w;
  endfunction

  // offer one item, idling first at random, and hold it until the transfer
  task automatic offer(input logic [FUNC_W-1:0] f, input in_word_t w,
                       input logic typed = 1'b0, input out_word_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= w;
    in_tuser   <= f;
    typed_tag  <= typed;
    typed_want <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering, wait for every pending result, then let the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_settings(input phase_t ph);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP;
    cfg_data  <= CFG_DATA_W'(ph.step);
    @(posedge clk);
    cfg_index <= CFG_LIMIT0;
    cfg_data  <= ph.l0;
    @(posedge clk);
    cfg_index <= CFG_LIMIT1;
    cfg_data  <= ph.l1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_tready   <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      squeeze_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // mirror config writes and input transfers, check result transfers
  always @(posedge clk) begin : scoreboard
    in_word_t  iw;
    out_word_t predicted;
    out_word_t got;
    out_word_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP:   step_sz = cfg_data[STEP_W-1:0];
          CFG_LIMIT0: lim_0 = cfg_data[LIMIT_W-1:0];
          CFG_LIMIT1: lim_1 = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        iw = in_word_t'(in_tdata);
        if (observe_step(in_tuser, iw, predicted))
          pending_estimates.push_back(typed_tag ? typed_want : predicted);
      end
      if (out_tvalid && out_tready) begin
        got = out_word_t'(out_tdata);
        if (pending_estimates.size() == 0) begin
          flag_mismatch($sformatf("result with no update pending: %h", out_tdata));
        end else begin
          want = pending_estimates.pop_front();
          for (int j = 0; j < NS; j++)
            if (got.est[j] !== want.est[j])
              flag_mismatch($sformatf("estimate_%0d got %h want %h",
                                      j, got.est[j], want.est[j]));
          for (int k = 0; k < ND; k++)
            if (got.disturb[k] !== want.disturb[k])
              flag_mismatch($sformatf("disturbance_%0d got %h want %h",
                                      k, got.disturb[k], want.disturb[k]));
        end
      end
    end
  end

  // end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("state_space_disturbance_observer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    in_word_t   word;
    out_word_t  want;
    probe_row_t row;
    phase_t     plan [5];
    logic [FUNC_W-1:0] f;
    int r;

    for (int k = 0; k < COEF_TOTAL; k++) begin
      coef_mirror[k] = '0;
      coef_seen[k]   = 1'b0;
    end
    for (int j = 0; j < NS; j++) est_mirror[j] = '0;
    for (int k = 0; k < ND; k++) dist_mirror[k] = '0;

    // settings per random phase: extremes, random picks, defaults
    plan[0] = '{24'hFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b0};
    plan[1] = '{24'h0, 31'h0, 31'h0, 1'b0, 1'b0};
    plan[2] = '{STEP_W'($urandom_range(1 << 20, 1)), LIMIT_W'($urandom()),
                LIMIT_W'($urandom_range(1 << 20)), 1'b0, 1'b1};
    plan[3] = '{STEP_RESET, LIMIT0_RESET, LIMIT1_RESET, 1'b1, 1'b0};
    plan[4] = '{STEP_W'($urandom()), LIMIT_W'($urandom_range(1 << 22)),
                LIMIT_W'($urandom()), 1'b0, 1'b0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the probe table
    foreach (probe_table[n]) begin
      row = probe_table[n];
      if (row.fill) begin
        for (int k = 0; k < COEF_TOTAL; k++) begin
          word      = '0;
          word.widx = WIDX_W'(k);
          word.wval = row.wval;
          offer(FUNC_COEF, word);
        end
      end else begin
        word = '0;
        for (int j = 0; j < NS; j++) word.meas[j] = row.meas;
        for (int k = 0; k < ND; k++) word.drv[k] = row.drv;
        word.widx = row.widx;
        word.wval = row.wval;
        for (int j = 0; j < NS; j++) want.est[j] = row.exp_est;
        want.disturb[0] = row.exp_d0;
        want.disturb[1] = row.exp_d1;
        offer(row.func, word, row.typed, want);
      end
    end

    // random phases
    foreach (plan[p]) begin
      program_settings(plan[p]);
      send_idle_pct = plan[p].calm ? 0 : 26;
      rx_idle_pct   = plan[p].calm ? 0 : 26;
      squeeze_req   = plan[p].squeeze;

      // fresh coefficient set with modest gains
      for (int k = 0; k < COEF_TOTAL; k++) begin
        word      = noisy_word();
        word.widx = WIDX_W'(k);
        word.wval = 32'($urandom_range(65535)) - 32'd32768;
        offer(FUNC_COEF, word);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        word = noisy_word();
        r = $urandom_range(99);
        if (r < 55) begin
          f = FUNC_UPDATE;
          for (int j = 0; j < NS; j++) word.meas[j] = pick_q16();
          for (int k = 0; k < ND; k++) word.drv[k] = pick_q16();
        end else if (r < 78) begin
          f = FUNC_COEF;
          word.widx = ($urandom_range(19) == 0) ? WIDX_W'($urandom_range(127, COEF_TOTAL))
                                                : WIDX_W'($urandom_range(COEF_TOTAL - 1));
          word.wval = pick_q16();
        end else if (r < 95) begin
          f = FUNC_PRESET;
          word.widx = ($urandom_range(9) == 0) ? WIDX_W'($urandom_range(127, NR))
                                               : WIDX_W'($urandom_range(NR - 1));
          word.wval = pick_q16();
        end else begin
          f = FUNC_SPARE;
        end
        offer(f, word);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("state_space_disturbance_observer verification clean");
    end else begin
      $display("state_space_disturbance_observer verification failed");
    end
    $finish;
  end

endmodule
